FILE: rtl/core/svm_pkg.sv
package svm_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned POOL_DEPTH_DEF  = 256;
  localparam int unsigned DIV_STEPS       = 96;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    CMD_CONST   = 3'd0,
    CMD_NEG     = 3'd1,
    CMD_ADD     = 3'd2,
    CMD_SUB     = 3'd3,
    CMD_MUL     = 3'd4,
    CMD_DIV     = 3'd5,
    CMD_RET     = 3'd6,
    CMD_POOL_WR = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_UNDER = 2'd1,
    STS_OVER  = 2'd2,
    STS_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_DISPATCH,
    S_PUSH,
    S_OPND,
    S_MUL,
    S_MULRND,
    S_DIV,
    S_DIVRND,
    S_WB
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [7:0]         pool_index;
    logic signed [63:0] pool_value;
  } in_req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    status_e            status;
  } out_req_t;

  // Decoded instruction handed from the front end to the execution unit.
  typedef struct packed {
    cmd_e        op;
    logic [1:0]  need;
    logic [7:0]  idx;
    logic [63:0] val;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? Q_MIN : Q_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] sat_neg(logic [63:0] a);
    return (a == Q_MIN) ? Q_MAX : (64'd0 - a);
  endfunction

  function automatic logic [63:0] signed_sat(logic neg, logic [63:0] mag, logic ovf);
    if (neg) begin
      if (ovf || (mag > Q_MIN)) begin
        return Q_MIN;
      end
      return 64'd0 - mag;
    end
    if (ovf || (mag > Q_MAX)) begin
      return Q_MAX;
    end
    return mag;
  endfunction

endpackage

FILE: rtl/core/svm_ram.sv
module svm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/svm_front.sv
module svm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  svm_pkg::in_req_t    in_req_i,
  output svm_pkg::front_out_t front_o,
  input  logic                take_i
);

  svm_pkg::in_req_t ent_q [2];
  logic             wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push, pop;
  svm_pkg::in_req_t head;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = take_i && (cnt_q != 2'd0);
  assign head       = ent_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  // Classify: how many operands each instruction consumes from the stack.
  always_comb begin
    front_o.valid    = (cnt_q != 2'd0);
    front_o.item.op  = head.cmd;
    front_o.item.idx = head.pool_index;
    front_o.item.val = head.pool_value;
    unique case (head.cmd)
      svm_pkg::CMD_ADD, svm_pkg::CMD_SUB,
      svm_pkg::CMD_MUL, svm_pkg::CMD_DIV: front_o.item.need = 2'd2;
      svm_pkg::CMD_NEG, svm_pkg::CMD_RET: front_o.item.need = 2'd1;
      default:                            front_o.item.need = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= in_req_i;
    end
  end

endmodule

FILE: rtl/core/svm_back.sv
module svm_back #(
  parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned POOL_DEPTH  = svm_pkg::POOL_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svm_pkg::front_out_t front_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output svm_pkg::out_req_t   out_req_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned PAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  svm_pkg::state_e   state_q, state_d;
  logic [SPW-1:0]    sp_q, sp_d;
  logic              flag_q, flag_d;
  logic              out_valid_q, out_valid_d;
  svm_pkg::out_req_t out_q, out_d;
  logic [63:0]       tos_q, tos_d;
  svm_pkg::cmd_e     op_q, op_d;
  logic              idx_ok_q, idx_ok_d;
  logic              neg_q, neg_d;
  logic [63:0]       ma_q, ma_d, mb_q, mb_d;
  logic [127:0]      acc_q, acc_d;
  logic [6:0]        cnt_q, cnt_d;
  logic [63:0]       rem_q, rem_d, mag_q, mag_d;
  logic              ovf_q, ovf_d;

  logic              pool_we;
  logic [PAW-1:0]    pool_addr;
  logic [63:0]       pool_rdata;
  logic              st_we;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [63:0]       st_rdata;

  logic [SPW-1:0]    sp_m1, sp_m2;
  logic              idx_ok, emit_free, underflow;
  logic [63:0]       opa, opb, mag_a, mag_b;
  logic [31:0]       pa, pb;
  logic [63:0]       prod;
  logic [64:0]       rem_sh, rem_sub;

  assign sp_m1     = sp_q - SPW'(1);
  assign sp_m2     = sp_q - SPW'(2);
  assign idx_ok    = ({1'b0, front_i.item.idx} < 9'(POOL_DEPTH));
  assign pool_addr = front_i.item.idx[PAW-1:0];
  assign st_raddr  = sp_m2[SAW-1:0];
  assign st_waddr  = sp_m1[SAW-1:0];
  assign emit_free = !out_valid_q || !out_stall_i;
  assign underflow = (sp_q < {{(SPW-2){1'b0}}, front_i.item.need});

  assign opa   = st_rdata;
  assign opb   = tos_q;
  assign mag_a = svm_pkg::magnitude(opa);
  assign mag_b = svm_pkg::magnitude(opb);

  assign pa   = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
  assign pb   = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
  assign prod = 64'(pa) * 64'(pb);

  assign rem_sh  = {rem_q, ma_q[63]};
  assign rem_sub = rem_sh - {1'b0, mb_q};

  svm_ram #(.WIDTH(64), .DEPTH(POOL_DEPTH)) u_pool (
    .clk_i  (clk_i),
    .we_i   (pool_we),
    .waddr_i(pool_addr),
    .wdata_i(front_i.item.val),
    .raddr_i(pool_addr),
    .rdata_o(pool_rdata)
  );

  svm_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(tos_q),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    tos_d       = tos_q;
    op_d        = op_q;
    idx_ok_d    = idx_ok_q;
    neg_d       = neg_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    mag_d       = mag_q;
    ovf_d       = ovf_q;
    take_o      = 1'b0;
    pool_we     = 1'b0;
    st_we       = 1'b0;

    unique case (state_q)
      svm_pkg::S_DISPATCH: begin
        if (front_i.valid) begin
          if (underflow) begin
            if (emit_free) begin
              take_o             = 1'b1;
              out_valid_d        = 1'b1;
              out_d.result_value = '0;
              out_d.status       = svm_pkg::STS_UNDER;
              sp_d               = '0;
              flag_d             = 1'b0;
            end
          end else begin
            unique case (front_i.item.op)
              svm_pkg::CMD_POOL_WR: begin
                take_o  = 1'b1;
                pool_we = idx_ok;
              end
              svm_pkg::CMD_CONST: begin
                if (sp_q == SPW'(STACK_DEPTH)) begin
                  if (emit_free) begin
                    take_o             = 1'b1;
                    out_valid_d        = 1'b1;
                    out_d.result_value = '0;
                    out_d.status       = svm_pkg::STS_OVER;
                    sp_d               = '0;
                    flag_d             = 1'b0;
                  end
                end else begin
                  take_o   = 1'b1;
                  idx_ok_d = idx_ok;
                  state_d  = svm_pkg::S_PUSH;
                end
              end
              svm_pkg::CMD_NEG: begin
                take_o = 1'b1;
                tos_d  = svm_pkg::sat_neg(tos_q);
              end
              svm_pkg::CMD_RET: begin
                if (emit_free) begin
                  take_o             = 1'b1;
                  out_valid_d        = 1'b1;
                  out_d.result_value = tos_q;
                  out_d.status       = flag_q ? svm_pkg::STS_DIVZ : svm_pkg::STS_OK;
                  sp_d               = '0;
                  flag_d             = 1'b0;
                end
              end
              default: begin
                take_o  = 1'b1;
                op_d    = front_i.item.op;
                state_d = svm_pkg::S_OPND;
              end
            endcase
          end
        end
      end

      svm_pkg::S_PUSH: begin
        st_we   = (sp_q != '0);
        tos_d   = idx_ok_q ? pool_rdata : 64'd0;
        sp_d    = sp_q + SPW'(1);
        state_d = svm_pkg::S_DISPATCH;
      end

      svm_pkg::S_OPND: begin
        neg_d = opa[63] ^ opb[63];
        ma_d  = mag_a;
        mb_d  = mag_b;
        unique case (op_q)
          svm_pkg::CMD_ADD: begin
            tos_d   = svm_pkg::sat_add(opa, opb);
            sp_d    = sp_m1;
            state_d = svm_pkg::S_DISPATCH;
          end
          svm_pkg::CMD_SUB: begin
            if (opb == svm_pkg::Q_MIN) begin
              tos_d = opa[63] ? (opa - opb) : svm_pkg::Q_MAX;
            end else begin
              tos_d = svm_pkg::sat_add(opa, 64'd0 - opb);
            end
            sp_d    = sp_m1;
            state_d = svm_pkg::S_DISPATCH;
          end
          svm_pkg::CMD_MUL: begin
            acc_d   = '0;
            cnt_d   = '0;
            state_d = svm_pkg::S_MUL;
          end
          default: begin
            if (mag_b == 64'd0) begin
              // Divide by zero saturates by the dividend's sign (a zero dividend gives
              // zero) and is remembered until the end of the run.
              flag_d = 1'b1;
              if (opa == 64'd0) begin
                tos_d = 64'd0;
              end else begin
                tos_d = opa[63] ? svm_pkg::Q_MIN : svm_pkg::Q_MAX;
              end
              sp_d    = sp_m1;
              state_d = svm_pkg::S_DISPATCH;
            end else begin
              rem_d   = '0;
              mag_d   = '0;
              ovf_d   = 1'b0;
              cnt_d   = '0;
              state_d = svm_pkg::S_DIV;
            end
          end
        endcase
      end

      svm_pkg::S_MUL: begin
        case (cnt_q[1:0])
          2'd0:    acc_d = acc_q + {64'd0, prod};
          2'd3:    acc_d = acc_q + {prod, 64'd0};
          default: acc_d = acc_q + {32'd0, prod, 32'd0};
        endcase
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = svm_pkg::S_MULRND;
        end
      end

      svm_pkg::S_MULRND: begin
        mag_d   = acc_q[95:32] + {63'd0, acc_q[31]};
        ovf_d   = (acc_q[127:96] != 32'd0) || (acc_q[31] && (&acc_q[95:32]));
        state_d = svm_pkg::S_WB;
      end

      svm_pkg::S_DIV: begin
        if (rem_sh >= {1'b0, mb_q}) begin
          rem_d = rem_sub[63:0];
        end else begin
          rem_d = rem_sh[63:0];
        end
        ovf_d = ovf_q | mag_q[63];
        mag_d = {mag_q[62:0], (rem_sh >= {1'b0, mb_q})};
        ma_d  = {ma_q[62:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(svm_pkg::DIV_STEPS - 1)) begin
          state_d = svm_pkg::S_DIVRND;
        end
      end

      svm_pkg::S_DIVRND: begin
        if (rem_q >= (mb_q - rem_q)) begin
          mag_d = mag_q + 64'd1;
          ovf_d = ovf_q | (&mag_q);
        end
        state_d = svm_pkg::S_WB;
      end

      svm_pkg::S_WB: begin
        tos_d   = svm_pkg::signed_sat(neg_q, mag_q, ovf_q);
        sp_d    = sp_m1;
        state_d = svm_pkg::S_DISPATCH;
      end

      default: state_d = svm_pkg::S_DISPATCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svm_pkg::S_DISPATCH;
      sp_q        <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    tos_q    <= tos_d;
    op_q     <= op_d;
    idx_ok_q <= idx_ok_d;
    neg_q    <= neg_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    acc_q    <= acc_d;
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    mag_q    <= mag_d;
    ovf_q    <= ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

FILE: rtl/core/stack_bytecode_arith_vm_top.sv
// Stack-machine arithmetic interpreter on signed Q32.32 values. Each request
// is one decoded instruction; a pool-write request fills the constant pool,
// which must be written before any constant instruction reads an entry.
// A return request, or any stack underflow or overflow, produces exactly one
// result request and empties the stack; all other instructions produce none.
// Arithmetic saturates; a divide by zero is reported by the next return
// unless an underflow or overflow result clears it first. Requests enter a
// two-entry queue that decodes them, so the input keeps flowing while the
// execution unit is busy or while a result waits behind out_stall_i in the
// output register. In the execution unit, pool write, negate and return
// are done at dispatch (a return, like an underflow or overflow result,
// also waits until the output register is free), a constant push adds a
// push step, add and subtract an operand fetch, multiply runs dispatch,
// operand fetch, four 32x32 partial products on one multiplier, rounding
// and write-back, and divide runs dispatch, operand fetch, one quotient bit
// per cycle over 96 steps in a restoring divider, rounding and write-back.
// The operand stack and the constant pool are single-port-read RAMs with a
// registered read; the top of the stack is kept in a register.
module stack_bytecode_arith_vm_top #(
  parameter int unsigned STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned POOL_DEPTH  = svm_pkg::POOL_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  svm_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output svm_pkg::out_req_t out_req_o
);

  // Decoded instruction at the head of the queue and the pop strobe.
  svm_pkg::front_out_t front;
  logic                take;

  svm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .front_o   (front),
    .take_i    (take)
  );

  svm_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .front_i    (front),
    .take_o     (take),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

endmodule
